/* src/uo_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uo_pkg
// Shared constants for the ultimate oscillator block.
// ----------------------------------------------------------------------------
package uo_pkg;
    localparam int unsigned MaxPeriodDefault = 64;
    localparam int unsigned PriceBitsDefault = 32;
    localparam int unsigned FracBits         = 16;
    localparam int unsigned OscMax           = 6553600;
    localparam int unsigned PeriodBits       = 7;
    localparam int unsigned OscBits          = 23;
    localparam logic [PeriodBits-1:0] ShortReset  = 7'd7;
    localparam logic [PeriodBits-1:0] MediumReset = 7'd14;
    localparam logic [PeriodBits-1:0] LongReset   = 7'd28;
    // register indexes
    localparam logic [1:0] RegShort  = 2'd0;
    localparam logic [1:0] RegMedium = 2'd1;
    localparam logic [1:0] RegLong   = 2'd2;
endpackage

/* src/ultimate_oscillator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultimate_oscillator_core
// Ultimate oscillator over price bars; range and pressure rings in memory.
// ----------------------------------------------------------------------------
// a new bar word can be taken in the cycle after the result is raised, and a stalled
// result holds the core in its output state. window sums are read one ring entry per
// cycle from one memory read port, and the three ratios share one radix-2 divider.
// reset is synchronous: control state, sums and periods return to defaults; ring
// contents stay undefined.
module ultimate_oscillator_core #(
    parameter int unsigned MAX_PERIOD = uo_pkg::MaxPeriodDefault,
    parameter int unsigned PRICE_BITS = uo_pkg::PriceBitsDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [PRICE_BITS-1:0]        i_bar_high,
    input  logic [PRICE_BITS-1:0]        i_bar_low,
    input  logic [PRICE_BITS-1:0]        i_bar_close,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [uo_pkg::OscBits-1:0]   o_oscillator,
    output logic                         o_zero_range
);
    localparam int unsigned AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int unsigned CW = $clog2(MAX_PERIOD + 1);
    localparam int unsigned SW = PRICE_BITS + CW;
    localparam int unsigned PB = uo_pkg::PeriodBits;
    localparam int unsigned QW = uo_pkg::FracBits + 3;
    localparam int unsigned DN = uo_pkg::FracBits + 4;
    localparam int unsigned WW = QW + 3;
    localparam int unsigned RW = 30;
    localparam int unsigned RS = 26;
    localparam int unsigned PW = WW + RW - RS;
    // ceil(100 * 2^26 / 7), exact for any weighted sum below 2^22
    localparam logic [RW-1:0] Recip = 30'd958698058;

    typedef enum logic [2:0] {
        S_IDLE, S_WRITE, S_READ, S_ACC, S_DIV, S_OUT
    } t_state;

    // configuration registers
    logic [PB-1:0] r_period [3];
    logic          wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period[0] <= uo_pkg::ShortReset;
            r_period[1] <= uo_pkg::MediumReset;
            r_period[2] <= uo_pkg::LongReset;
        end else if (wr_en) begin
            case (paddr[3:2])
                uo_pkg::RegShort:  r_period[0] <= pwdata[PB-1:0];
                uo_pkg::RegMedium: r_period[1] <= pwdata[PB-1:0];
                uo_pkg::RegLong:   r_period[2] <= pwdata[PB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            uo_pkg::RegShort:  prdata[PB-1:0] = r_period[0];
            uo_pkg::RegMedium: prdata[PB-1:0] = r_period[1];
            uo_pkg::RegLong:   prdata[PB-1:0] = r_period[2];
            default: ;
        endcase
    end

    // effective periods, clipped to 1..MAX_PERIOD
    logic [CW-1:0] eff [3];
    logic [CW-1:0] need;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_period[k] == '0) eff[k] = CW'(1);
            else if (32'(r_period[k]) > MAX_PERIOD) eff[k] = CW'(MAX_PERIOD);
            else eff[k] = CW'(r_period[k]);
        end
        need = eff[0];
        if (eff[1] > need) need = eff[1];
        if (eff[2] > need) need = eff[2];
    end

    // ring memory: range and pressure side by side
    logic [2*PRICE_BITS-1:0] mem [MAX_PERIOD];
    logic                    mem_we;
    logic [AW-1:0]           mem_wa, mem_ra;
    logic [2*PRICE_BITS-1:0] mem_wd, mem_rd;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_rd <= mem[mem_ra];
    end

    t_state              r_state;
    logic [AW-1:0]       r_slot, r_idx;
    logic [CW-1:0]       r_seen, r_cnt;
    logic [PRICE_BITS-1:0] r_prev, r_tr, r_bp;
    logic [SW-1:0]       r_rs [3];
    logic [SW-1:0]       r_ps [3];
    logic [1:0]          r_k;
    logic [4:0]          r_bit;
    logic [SW:0]         r_rem;
    logic [QW-1:0]       r_q;
    logic [WW-1:0]       r_wsum;
    logic                r_zero, r_rd_ok;
    logic                r_ovalid;
    logic [uo_pkg::OscBits-1:0] r_osc;
    logic                r_ozero;

    // true range and buying pressure of the incoming bar
    logic [PRICE_BITS-1:0] top, bot, tr_in, bp_in;
    always_comb begin
        top = (i_bar_high > r_prev) ? i_bar_high : r_prev;
        bot = (i_bar_low < r_prev) ? i_bar_low : r_prev;
        if (r_seen == '0) tr_in = (i_bar_high >= i_bar_low) ? i_bar_high - i_bar_low : '0;
        else tr_in = top - bot;
        bp_in = (i_bar_close >= i_bar_low) ? i_bar_close - i_bar_low : '0;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign mem_we       = (r_state == S_WRITE);
    assign mem_wa       = r_slot;
    assign mem_wd       = {r_tr, r_bp};
    assign mem_ra       = r_idx;
    assign o_valid      = r_ovalid;
    assign o_oscillator = r_osc;
    assign o_zero_range = r_ozero;

    // shared divider: one quotient bit per cycle, capped at 7.0
    logic [SW-1:0] den, num;
    logic [SW:0]   rem_sh;
    logic          take;
    logic [SW+3:0] den7;
    always_comb begin
        den    = r_rs[r_k];
        num    = r_ps[r_k];
        den7   = (SW+4)'(den) * (SW+4)'(7);
        rem_sh = {r_rem[SW-1:0], 1'b0};
        take   = (rem_sh >= {1'b0, den});
    end

    // final scaling by 100/7 through a reciprocal multiplication
    logic [WW+RW-1:0] scaled;
    logic [PW-1:0]    osc_full;
    assign scaled   = (WW+RW)'(r_wsum) * (WW+RW)'(Recip);
    assign osc_full = scaled[WW+RW-1:RS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_seen   <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
            r_rd_ok  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_rs[k] <= '0;
                r_ps[k] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tr    <= tr_in;
                        r_bp    <= bp_in;
                        r_prev  <= i_bar_close;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_slot <= (32'(r_slot) == MAX_PERIOD - 1) ? '0 : r_slot + 1'b1;
                    if (32'(r_seen) < MAX_PERIOD) r_seen <= r_seen + 1'b1;
                    r_idx   <= r_slot;
                    r_cnt   <= '0;
                    r_rd_ok <= 1'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_rs[k] <= '0;
                        r_ps[k] <= '0;
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    // one entry per cycle: issue read, accumulate prior data
                    if (r_rd_ok) begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_cnt <= eff[k]) begin
                                r_rs[k] <= r_rs[k] + SW'(mem_rd[2*PRICE_BITS-1:PRICE_BITS]);
                                r_ps[k] <= r_ps[k] + SW'(mem_rd[PRICE_BITS-1:0]);
                            end
                        end
                    end
                    if (r_cnt < need && r_cnt < r_seen) begin
                        r_rd_ok <= 1'b1;
                        r_cnt   <= r_cnt + 1'b1;
                        r_idx   <= (r_idx == '0) ? AW'(MAX_PERIOD - 1) : r_idx - 1'b1;
                    end else begin
                        r_rd_ok <= 1'b0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_seen < need) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= '0;
                        r_bit   <= '0;
                        r_wsum  <= '0;
                        r_zero  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == '0) begin
                        // zero divisor, cap at 7.0, or start the restoring steps
                        if (den == '0) begin
                            r_q   <= '0;
                            r_zero <= 1'b1;
                            r_bit <= 5'(DN);
                        end else if ((SW+4)'(num) >= den7) begin
                            r_q   <= QW'(7) << uo_pkg::FracBits;
                            r_bit <= 5'(DN);
                        end else begin
                            r_rem <= {1'b0, num};
                            r_q   <= '0;
                            r_bit <= 5'd1;
                        end
                    end else if (r_bit < 5'(DN)) begin
                        // restoring step: 3 integer bits then 16 fraction bits
                        if (r_bit <= 5'd3) begin
                            if ((SW+1)'(r_rem) >= ({1'b0, den} << (3 - r_bit))) begin
                                r_rem <= r_rem - ({1'b0, den} << (3 - r_bit));
                                r_q   <= r_q | (QW'(1) << (3 - 32'(r_bit)));
                            end
                            r_bit <= r_bit + 1'b1;
                        end else begin
                            r_rem <= take ? rem_sh - {1'b0, den} : rem_sh;
                            r_q   <= {r_q[QW-2:0], take};
                            r_bit <= r_bit + 1'b1;
                        end
                    end else begin
                        r_wsum <= r_wsum + ((r_k == 2'd0) ? (WW'(r_q) << 2) :
                                  (r_k == 2'd1) ? (WW'(r_q) << 1) : WW'(r_q));
                        r_bit  <= '0;
                        if (r_k == 2'd2) r_state <= S_OUT;
                        else r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_osc    <= (osc_full > PW'(uo_pkg::OscMax)) ?
                                    uo_pkg::OscBits'(uo_pkg::OscMax) :
                                    osc_full[uo_pkg::OscBits-1:0];
                        r_ozero  <= r_zero;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_seen_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_seen) <= MAX_PERIOD) else $error("bars_seen overflow");
    a_osc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_oscillator) <= uo_pkg::OscMax)) else $error("osc range");
endmodule

/* verif/tb_ultimate_oscillator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultimate_oscillator_core
// Feeds price bars through the oscillator core, predicts each word from an
// in-bench model of the rings, window sums and ratios, and compares results
// field by field under random idling on both sides and several period settings.
// ----------------------------------------------------------------------------
module tb_ultimate_oscillator_core;

    localparam int unsigned Depth = 64;

    typedef struct packed {
        logic [31:0] high;
        logic [31:0] low;
        logic [31:0] close;
    } t_bar;

    typedef struct packed {
        logic [uo_pkg::OscBits-1:0] osc;
        logic                       zero;
    } t_osc_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_bar_high = '0, i_bar_low = '0, i_bar_close = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [uo_pkg::OscBits-1:0] o_oscillator;
    logic        o_zero_range;

    ultimate_oscillator_core uut (.*);

    always #5 i_clk = ~i_clk;

    // bench-side copy of the core state
    logic [31:0] range_hist [Depth];
    logic [31:0] press_hist [Depth];
    int unsigned hist_slot = 0, hist_count = 0;
    logic [31:0] last_close = '0;
    logic [uo_pkg::PeriodBits-1:0] periods [3] =
        '{uo_pkg::ShortReset, uo_pkg::MediumReset, uo_pkg::LongReset};

    t_bar      bar_queue [$];
    t_osc_word osc_expected [$];
    int unsigned mismatches = 0, words_seen = 0, bars_sent = 0;
    bit        quiet = 1'b0;
    int        drv_idle = 0, mon_idle = 0;

    // ratio with 16 fraction bits, held at 7.0
    function automatic logic [63:0] ratio_q16(logic [63:0] num, logic [63:0] den);
        logic [63:0] whole, rem, frac;
        if (num >= den * 7) return 64'd7 << uo_pkg::FracBits;
        whole = num / den;
        rem = num - whole * den;
        frac = 0;
        for (int i = 0; i < uo_pkg::FracBits; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
                rem = rem - den;
                frac[0] = 1'b1;
            end
        end
        return (whole << uo_pkg::FracBits) | frac;
    endfunction

    // advance the state by one bar and queue the word it yields
    task automatic predict_oscillator(t_bar b);
        logic [31:0] tr, bp;
        logic [63:0] rs, ps, weighted, osc;
        int unsigned p, need, idx, cur;
        bit zero;
        if (hist_count == 0) tr = (b.high >= b.low) ? b.high - b.low : 0;
        else tr = ((b.high > last_close) ? b.high : last_close)
                - ((b.low < last_close) ? b.low : last_close);
        bp = (b.close >= b.low) ? b.close - b.low : 0;
        range_hist[hist_slot] = tr;
        press_hist[hist_slot] = bp;
        cur = hist_slot;
        hist_slot = (hist_slot + 1) % Depth;
        if (hist_count < Depth) hist_count++;
        last_close = b.close;
        need = 0;
        weighted = 0;
        zero = 1'b0;
        for (int k = 0; k < 3; k++) begin
            p = (periods[k] == 0) ? 1 : (periods[k] > Depth) ? Depth : periods[k];
            if (p > need) need = p;
        end
        if (hist_count < need) return;
        for (int k = 0; k < 3; k++) begin
            p = (periods[k] == 0) ? 1 : (periods[k] > Depth) ? Depth : periods[k];
            rs = 0;
            ps = 0;
            idx = cur;
            for (int i = 0; i < p; i++) begin
                rs += range_hist[idx];
                ps += press_hist[idx];
                idx = (idx == 0) ? Depth - 1 : idx - 1;
            end
            if (rs == 0) zero = 1'b1;
            else weighted += (64'd4 >> k) * ratio_q16(ps, rs);
        end
        osc = weighted * 100 / 7;
        if (osc > uo_pkg::OscMax) osc = uo_pkg::OscMax;
        osc_expected.push_back('{osc: osc[uo_pkg::OscBits-1:0], zero: zero});
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // driver: one bar word per accept, random idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_oscillator('{high: i_bar_high, low: i_bar_low, close: i_bar_close});
                bars_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (drv_idle > 0) begin
                    drv_idle--;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 19) == 0) begin
                    drv_idle = $urandom_range(1, 15);
                    i_valid <= 1'b0;
                end else if (bar_queue.size() > 0) begin
                    t_bar b;
                    b = bar_queue.pop_front();
                    i_valid <= 1'b1;
                    i_bar_high <= b.high;
                    i_bar_low <= b.low;
                    i_bar_close <= b.close;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                words_seen++;
                if (osc_expected.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    t_osc_word e;
                    e = osc_expected.pop_front();
                    if (o_oscillator !== e.osc)
                        report_mismatch($sformatf("oscillator %0d, expected %0d",
                                                  o_oscillator, e.osc));
                    if (o_zero_range !== e.zero)
                        report_mismatch($sformatf("zero_range %0b, expected %0b",
                                                  o_zero_range, e.zero));
                end
            end
            if (mon_idle > 0) begin
                mon_idle--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 19) == 0) begin
                mon_idle = $urandom_range(1, 15);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_period(logic [1:0] index, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index < 3) periods[index] = value[uo_pkg::PeriodBits-1:0];
    endtask

    task automatic set_periods(logic [31:0] s, logic [31:0] m, logic [31:0] l);
        write_period(uo_pkg::RegShort, s);
        write_period(uo_pkg::RegMedium, m);
        write_period(uo_pkg::RegLong, l);
    endtask

    // wait for the core to drain, plus its worst-case latency
    task automatic drain;
        while (bar_queue.size() > 0 || i_valid || osc_expected.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_price(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 3);
            2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return 32'd100000 + $urandom_range(0, 2000);
        endcase
    endfunction

    // bar with low <= close <= high; broken ones in mode 0 and one in ten otherwise
    task automatic push_random_bar(int mode);
        logic [31:0] a, b, c;
        if ($urandom_range(0, 9) == 0 || mode == 0) begin
            a = rand_price(mode);
            b = rand_price(mode);
            c = rand_price(mode);
        end else begin
            a = rand_price(mode);
            b = rand_price(mode);
            if (a < b) begin
                c = a; a = b; b = c;
            end
            c = b + ((a - b) == 0 ? 0 : $urandom_range(0, a - b));
        end
        bar_queue.push_back('{high: a, low: b, close: c});
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first bar with low above high, extremes, flat bars
        bar_queue.push_back('{high: 32'd5, low: 32'd9, close: 32'd7});
        bar_queue.push_back('{high: '1, low: '0, close: '1});
        bar_queue.push_back('{high: '1, low: '0, close: '0});
        bar_queue.push_back('{high: 32'd10, low: 32'd20, close: 32'd5});
        for (int i = 0; i < 24; i++)
            bar_queue.push_back('{high: 32'd50, low: 32'd50, close: 32'd50});
        drain();
        // tiny windows: zero range and close below low
        set_periods(1, 1, 1);
        bar_queue.push_back('{high: 32'd50, low: 32'd50, close: 32'd50});
        bar_queue.push_back('{high: 32'd60, low: 32'd40, close: 32'd30});
        bar_queue.push_back('{high: 32'd60, low: 32'd40, close: 32'd60});
        bar_queue.push_back('{high: '1, low: '1, close: '1});
        bar_queue.push_back('{high: '0, low: '0, close: '0});
        drain();
        // out of range periods act as 1 and 64; ignored register
        set_periods(0, 32'hFFFF_FF7F, 100);
        write_period(2'd3, 32'h5A);
        for (int i = 0; i < 70; i++) push_random_bar(0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) quiet = 1'b1;
            case (ph)
                0: set_periods(7, 14, 28);
                1: set_periods(64, 64, 64);
                2: set_periods(1, 2, 3);
                3: set_periods(64, 1, 32);
                default: set_periods($urandom_range(0, 127), $urandom_range(0, 70),
                                     $urandom_range(1, 64));
            endcase
            for (int i = 0; i < 160; i++) push_random_bar($urandom_range(0, 3));
            drain();
        end

        $display("sent %0d bars and checked %0d result words over several period settings",
                 bars_sent, words_seen);
        if (mismatches == 0 && osc_expected.size() == 0)
            $display("tb_ultimate_oscillator_core: PASS");
        else
            $display("tb_ultimate_oscillator_core: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_ultimate_oscillator_core: FAIL");
        $finish;
    end
endmodule

/* files.f */
src/uo_pkg.sv
src/ultimate_oscillator_core.sv
verif/tb_ultimate_oscillator_core.sv
